@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/mks_pkg.sv @@
// types, constants and keymap for the matrix keypad scanner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mks_pkg;

    localparam int COUNTER_WIDTH_DEF = 20;
    localparam int CFG_DATA_W        = 20;
    localparam int CFG_INDEX_W       = 4;
    localparam int SETTLE_RESET      = 50;
    localparam int DEBOUNCE_RESET    = 20000;

    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = CFG_INDEX_W'(1);

    localparam logic [3:0] ROWS_IDLE = 4'hF;

    typedef enum logic [3:0] {
        PH_SETTLE      = 4'b0001,
        PH_DEB_PRESS   = 4'b0010,
        PH_RELEASE     = 4'b0100,
        PH_DEB_RELEASE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       found;
        logic [1:0] column;
    } col_hit_t;

    localparam logic [7:0] KEYMAP [16] = '{
        8'h31, 8'h32, 8'h33, 8'h2F,
        8'h34, 8'h35, 8'h36, 8'h2A,
        8'h37, 8'h38, 8'h39, 8'h2D,
        8'h43, 8'h30, 8'h3D, 8'h2B
    };

    // lowest low column at or above start
    function automatic col_hit_t find_low(input logic [3:0] cols, input logic [2:0] start);
        col_hit_t hit;
        hit = '0;
        for (int c = 3; c >= 0; c--)
        begin
            if (!cols[c] && (3'(c) >= start))
            begin
                hit.found  = 1'b1;
                hit.column = 2'(c);
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/matrix_keypad_scanner_core.sv @@
// debounced 4x4 matrix keypad scanner, single-module core
// depends on mks_pkg and assert_macros.svh
//
// usage: each request on the input channel (in_valid/in_ready) is one timing
// tick carrying the sampled column pins, active low. every tick gives exactly
// one result on the output channel (out_valid/out_ready): the row drive for
// that tick and, on the tick a debounced press-and-release completes, the
// key index and its ascii code with key_valid set.
// the scan state advances once per accepted request in one registered pass,
// so a result appears in the cycle after its request is accepted and a new
// request can be taken every cycle while the receiver takes the results.
// when the receiver stalls, the result stays in the output register and the
// input is still taken in the cycle the waiting result is taken.
// config writes (cfg_valid/cfg_ready, always ready) set settle_ticks (index 0)
// and debounce_ticks (index 1); other indexes are ignored.
// reset: settle phase on row 0, count cleared, registers to 50 and 20000,
// output register empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module matrix_keypad_scanner_core #(
    parameter int COUNTER_WIDTH = mks_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [3:0]                       column_levels,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [3:0]                            row_drive,
    output logic                                  key_valid,
    output logic [3:0]                            key_index,
    output logic [7:0]                            key_char,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mks_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mks_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import mks_pkg::*;

    logic [COUNTER_WIDTH-1:0] settle_reg;
    logic [COUNTER_WIDTH-1:0] debounce_reg;

    phase_t                   phase_reg, phase_next;
    logic [1:0]               row_reg, row_next;
    logic [1:0]               col_reg, col_next;
    logic [COUNTER_WIDTH-1:0] wait_reg, wait_next;

    logic                     out_valid_reg;
    logic [3:0]               row_drive_reg, row_drive_next;
    logic                     key_valid_reg, key_valid_next;
    logic [3:0]               key_index_reg, key_index_next;
    logic [7:0]               key_char_reg, key_char_next;

    logic                     in_acc;
    logic                     settle_busy;
    logic                     debounce_busy;
    logic [COUNTER_WIDTH-1:0] wait_inc;
    col_hit_t                 hit_any;
    col_hit_t                 hit_above;
    logic                     col_low;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_acc    = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign row_drive = row_drive_reg;
    assign key_valid = key_valid_reg;
    assign key_index = key_index_reg;
    assign key_char  = key_char_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= COUNTER_WIDTH'(SETTLE_RESET);
            debounce_reg <= COUNTER_WIDTH'(DEBOUNCE_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SETTLE)
            begin
                settle_reg <= COUNTER_WIDTH'(cfg_data);
            end
            else if (cfg_index == REG_DEBOUNCE)
            begin
                debounce_reg <= COUNTER_WIDTH'(cfg_data);
            end
        end
    end

    assign settle_busy   = wait_reg < settle_reg;
    assign debounce_busy = wait_reg < debounce_reg;
    assign wait_inc      = wait_reg + COUNTER_WIDTH'(1);
    assign hit_any       = find_low(column_levels, 3'd0);
    assign hit_above     = find_low(column_levels, {1'b0, col_reg} + 3'd1);
    assign col_low       = !column_levels[col_reg];

    // one scan tick
    always_comb
    begin
        phase_next     = phase_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        wait_next      = wait_reg;
        row_drive_next = ~(4'b0001 << row_reg);
        key_valid_next = 1'b0;
        key_index_next = 4'd0;
        key_char_next  = 8'd0;
        unique case (phase_reg)
            PH_SETTLE:
            begin
                if (settle_busy)
                begin
                    wait_next = wait_inc;
                end
                else if (hit_any.found)
                begin
                    col_next   = hit_any.column;
                    wait_next  = '0;
                    phase_next = PH_DEB_PRESS;
                end
                else
                begin
                    row_next  = row_reg + 2'd1;
                    col_next  = 2'd0;
                    wait_next = '0;
                end
            end
            PH_DEB_PRESS:
            begin
                if (debounce_busy)
                begin
                    wait_next = wait_inc;
                end
                else if (col_low)
                begin
                    wait_next  = '0;
                    phase_next = PH_RELEASE;
                end
                else if (hit_above.found)
                begin
                    col_next  = hit_above.column;
                    wait_next = '0;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    col_next   = 2'd0;
                    wait_next  = '0;
                    phase_next = PH_SETTLE;
                end
            end
            PH_RELEASE:
            begin
                if (!col_low)
                begin
                    wait_next  = '0;
                    phase_next = PH_DEB_RELEASE;
                end
            end
            PH_DEB_RELEASE:
            begin
                if (debounce_busy)
                begin
                    wait_next = wait_inc;
                end
                else
                begin
                    row_drive_next = ROWS_IDLE;
                    key_valid_next = 1'b1;
                    key_index_next = {row_reg, col_reg};
                    key_char_next  = KEYMAP[{row_reg, col_reg}];
                    row_next       = 2'd0;
                    col_next       = 2'd0;
                    wait_next      = '0;
                    phase_next     = PH_SETTLE;
                end
            end
            default:
            begin
                phase_next = PH_SETTLE;
            end
        endcase
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SETTLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
            wait_reg  <= '0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            wait_reg  <= wait_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            row_drive_reg <= row_drive_next;
            key_valid_reg <= key_valid_next;
            key_index_reg <= key_index_next;
            key_char_reg  <= key_char_next;
        end
    end

    // a report always releases every row
    `ASSERT_SAME(a_report_rows_idle, clk, rst_n, out_valid_reg && key_valid_reg,
        row_drive_reg == ROWS_IDLE && key_char_reg != 8'd0)
    // the release wait never counts
    `ASSERT_SAME(a_release_no_count, clk, rst_n, phase_reg == PH_RELEASE, wait_reg == '0)
    // after a report the scan restarts on row 0
    `ASSERT_NEXT(a_report_restart, clk, rst_n, in_acc && key_valid_next,
        phase_reg == PH_SETTLE && row_reg == 2'd0 && wait_reg == '0)

endmodule

`default_nettype wire
